### sv/sta_pkg.sv
// ---------------------------------------------------------------------------
// Swizzled texel address package
// Shared widths, register indexes and the geometry struct passed from the
// register block to the position walker.
// ---------------------------------------------------------------------------
package sta_pkg;

   localparam int MAX_SIZE_LOG2_DEFAULT = 9;

   localparam int TEXEL_WIDTH  = 32;
   localparam int INDEX_WIDTH  = 18;
   localparam int LOG2_WIDTH   = 4;
   localparam int ORIGIN_WIDTH = 9;

   // A tile is 4 texels wide (2 X bits) and 8 rows tall (3 Y bits).
   localparam int LIN_X_BITS = 2;
   localparam int LIN_Y_BITS = 3;
   localparam int LIN_BITS   = LIN_X_BITS + LIN_Y_BITS;

   localparam int MIN_WIDTH_LOG2  = LIN_X_BITS;
   localparam int MIN_HEIGHT_LOG2 = LIN_Y_BITS;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = ORIGIN_WIDTH;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WIDTH_LOG2  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HEIGHT_LOG2 = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ORIGIN_X    = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ORIGIN_Y    = 2'd3;

   localparam logic [LOG2_WIDTH-1:0] WIDTH_LOG2_RESET  = 4'd9;
   localparam logic [LOG2_WIDTH-1:0] HEIGHT_LOG2_RESET = 4'd9;

   // Texture geometry: number of upper X and Y index bits, and the origin.
   typedef struct packed {
      logic [LOG2_WIDTH-1:0]   x_ext;
      logic [LOG2_WIDTH-1:0]   y_ext;
      logic [ORIGIN_WIDTH-1:0] origin_x;
      logic [ORIGIN_WIDTH-1:0] origin_y;
   } sta_geom_type;

endpackage

### sv/sta_cfg.sv
// ---------------------------------------------------------------------------
// Swizzled texel address register block
// Holds the size and origin registers and derives the clamped geometry.
// ---------------------------------------------------------------------------
module sta_cfg import sta_pkg::*; #(
   parameter int MAX_SIZE_LOG2 = MAX_SIZE_LOG2_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   output sta_geom_type               geom
);

   logic [LOG2_WIDTH-1:0]   width_log2_ff, width_log2_in;
   logic [LOG2_WIDTH-1:0]   height_log2_ff, height_log2_in;
   logic [ORIGIN_WIDTH-1:0] origin_x_ff, origin_x_in;
   logic [ORIGIN_WIDTH-1:0] origin_y_ff, origin_y_in;
   logic [LOG2_WIDTH-1:0]   width_clamped;
   logic [LOG2_WIDTH-1:0]   height_clamped;

   localparam logic [LOG2_WIDTH-1:0] MaxLog2   = LOG2_WIDTH'(MAX_SIZE_LOG2);
   localparam logic [LOG2_WIDTH-1:0] MinWidth  = LOG2_WIDTH'(MIN_WIDTH_LOG2);
   localparam logic [LOG2_WIDTH-1:0] MinHeight = LOG2_WIDTH'(MIN_HEIGHT_LOG2);

   always_comb begin
      width_log2_in  = width_log2_ff;
      height_log2_in = height_log2_ff;
      origin_x_in    = origin_x_ff;
      origin_y_in    = origin_y_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_WIDTH_LOG2:  width_log2_in  = csr_write_data[LOG2_WIDTH-1:0];
            CSR_HEIGHT_LOG2: height_log2_in = csr_write_data[LOG2_WIDTH-1:0];
            CSR_ORIGIN_X:    origin_x_in    = csr_write_data;
            CSR_ORIGIN_Y:    origin_y_in    = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_log2_ff  <= WIDTH_LOG2_RESET;
         height_log2_ff <= HEIGHT_LOG2_RESET;
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
      end else begin
         width_log2_ff  <= width_log2_in;
         height_log2_ff <= height_log2_in;
         origin_x_ff    <= origin_x_in;
         origin_y_ff    <= origin_y_in;
      end
   end

   // Sizes below one tile act as one tile; oversized textures are capped.
   always_comb begin
      if (width_log2_ff < MinWidth) begin
         width_clamped = MinWidth;
      end else if (width_log2_ff > MaxLog2) begin
         width_clamped = MaxLog2;
      end else begin
         width_clamped = width_log2_ff;
      end
      if (height_log2_ff < MinHeight) begin
         height_clamped = MinHeight;
      end else if (height_log2_ff > MaxLog2) begin
         height_clamped = MaxLog2;
      end else begin
         height_clamped = height_log2_ff;
      end
   end

   assign geom.x_ext    = width_clamped - MinWidth;
   assign geom.y_ext    = height_clamped - MinHeight;
   assign geom.origin_x = origin_x_ff;
   assign geom.origin_y = origin_y_ff;

endmodule

### sv/sta_walk.sv
// ---------------------------------------------------------------------------
// Swizzled texel address walker
// Keeps the column and row in masked form and forms the swizzled index.
// ---------------------------------------------------------------------------
module sta_walk import sta_pkg::*; #(
   parameter int MAX_SIZE_LOG2 = MAX_SIZE_LOG2_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sta_geom_type           geom,
   input  logic                   accept,
   input  logic                   first_texel,
   input  logic                   row_end,
   output logic [INDEX_WIDTH-1:0] word_index
);

   localparam int PosWidth = 2 * MAX_SIZE_LOG2;
   localparam logic [PosWidth-1:0] PosOne   = PosWidth'(1);
   localparam logic [PosWidth-1:0] LinXMask = PosWidth'((1 << LIN_X_BITS) - 1);

   logic [PosWidth-1:0]   col_ff, col_in;
   logic [PosWidth-1:0]   row_ff, row_in;
   logic [PosWidth-1:0]   mask_x, mask_y;
   logic [PosWidth-1:0]   start_col, start_row;
   logic [PosWidth-1:0]   col_cur, row_cur;
   logic [LOG2_WIDTH:0]   y_high_shift;

   // Y's upper bits sit above the tile bits and X's upper bits.
   assign y_high_shift = (LOG2_WIDTH + 1)'(LIN_BITS) + (LOG2_WIDTH + 1)'(geom.x_ext);

   assign mask_x = LinXMask | (((PosOne << geom.x_ext) - PosOne) << LIN_BITS);
   assign mask_y = (LinXMask ^ ((PosOne << LIN_BITS) - PosOne))
                 | (((PosOne << geom.y_ext) - PosOne) << y_high_shift);

   // Deposit the origins into the mask bits; origin bits beyond the size drop.
   assign start_col = ((PosWidth'(geom.origin_x >> LIN_X_BITS) << LIN_BITS) & mask_x)
                    | PosWidth'(geom.origin_x[LIN_X_BITS-1:0]);
   assign start_row = ((PosWidth'(geom.origin_y >> LIN_Y_BITS) << y_high_shift) & mask_y)
                    | (PosWidth'(geom.origin_y[LIN_Y_BITS-1:0]) << LIN_X_BITS);

   assign col_cur = first_texel ? start_col : col_ff;
   assign row_cur = first_texel ? start_row : row_ff;

   assign word_index = INDEX_WIDTH'((col_cur & mask_x) | (row_cur & mask_y));

   // Subtracting the mask carries through the gaps between mask bits.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = start_col;
            row_in = (row_cur - mask_y) & mask_y;
         end else begin
            col_in = (col_cur - mask_x) & mask_x;
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

### sv/swizzled_texel_address_core.sv
// ---------------------------------------------------------------------------
// Swizzled texel address core
// Pairs each texel of a row-order upload with its word index in a tiled
// layout of 4 texels by 8 rows per tile.
// ---------------------------------------------------------------------------
// One item is accepted every cycle unless the input side stalls, and its result
// appears in the output register in the cycle after; the index is formed by a
// single masked OR and select path between the position registers and that
// output register. The input side stalls only while a held result is itself
// stalled. Size and origin registers take effect on the next item after a write.
module swizzled_texel_address_core import sta_pkg::*; #(
   parameter int MAX_SIZE_LOG2 = MAX_SIZE_LOG2_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [TEXEL_WIDTH-1:0]     req_texel,
   input  logic                       req_first_texel,
   input  logic                       req_row_end,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [INDEX_WIDTH-1:0]     rsp_word_index,
   output logic [TEXEL_WIDTH-1:0]     rsp_texel_out
);

   sta_geom_type           geom;
   logic                   req_accept;
   logic [INDEX_WIDTH-1:0] word_index;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [INDEX_WIDTH-1:0] rsp_word_index_ff;
   logic [TEXEL_WIDTH-1:0] rsp_texel_out_ff;

   sta_cfg #(
      .MAX_SIZE_LOG2(MAX_SIZE_LOG2)
   ) u_cfg (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .geom             (geom)
   );

   sta_walk #(
      .MAX_SIZE_LOG2(MAX_SIZE_LOG2)
   ) u_walk (
      .clock       (clock),
      .reset       (reset),
      .geom        (geom),
      .accept      (req_accept),
      .first_texel (req_first_texel),
      .row_end     (req_row_end),
      .word_index  (word_index)
   );

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_word_index_ff <= word_index;
         rsp_texel_out_ff  <= req_texel;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_word_index = rsp_word_index_ff;
   assign rsp_texel_out  = rsp_texel_out_ff;

   // The input side holds off only behind a stalled result.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a stalled result");

   // An accepted item always shows up in the output register next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (rsp_valid && rsp_texel_out == $past(req_texel)))
      else $error("accepted item missing from output register");

   // A result that is taken with no new item behind it leaves the register empty.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !req_accept) |=> !rsp_valid)
      else $error("delivered result repeated");

endmodule
